FILE: rtl/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg: shared constants and types of the register slot allocator
// Table size, id width, command and status codes, register indexes and the
// priority pick record passed between the encoder and the top level.
// ----------------------------------------------------------------------------
package rsa_pkg;

  // Table geometry
  localparam int NUM_REGS = 16;
  localparam int ID_BITS  = 16;
  localparam int REG_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Fixed field widths of the command and result transactions
  localparam int CMD_W    = 3;
  localparam int VID_W    = 16;
  localparam int OPW_W    = 2;
  localparam int RIDX_W   = 4;
  localparam int STAT_W   = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Reset values of the two mask registers
  localparam logic [CFG_W-1:0] ALLOC_MASK_RST = 16'hFF77;
  localparam logic [CFG_W-1:0] SAVE_MASK_RST  = 16'hF042;

  // Width codes for 64 and 32 bits
  localparam logic [OPW_W-1:0] OPW_64 = 2'd3;
  localparam logic [OPW_W-1:0] OPW_32 = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC_ANY   = 3'd0,
    CMD_ALLOC_FIXED = 3'd1,
    CMD_RELEASE     = 3'd2,
    CMD_WIDEN       = 3'd3,
    CMD_LOOKUP      = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NONE_FREE = 3'd1,
    ST_REG_BUSY  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_ZERO_ID   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALLOC_MASK = 1'b0,
    CFG_SAVE_MASK  = 1'b1
  } cfg_idx_e;

  // Result of a lowest-set-bit search
  typedef struct packed {
    logic             found;
    logic [REG_W-1:0] idx;
  } pick_t;

  // Map a 16-bit register mask onto the table; entries above bit 15 stay clear
  function automatic logic [NUM_REGS-1:0] fit_mask(logic [CFG_W-1:0] v);
    logic [NUM_REGS-1:0] m;
    for (int i = 0; i < NUM_REGS; i++) begin
      m[i] = (i < CFG_W) ? v[i % CFG_W] : 1'b0;
    end
    return m;
  endfunction

endpackage

FILE: rtl/rsa_lowest_set.sv
// ----------------------------------------------------------------------------
// rsa_lowest_set: priority encoder
// Reports whether any request bit is set and the index of the lowest one.
// ----------------------------------------------------------------------------
module rsa_lowest_set (
  input  logic [rsa_pkg::NUM_REGS-1:0] req_i,
  output rsa_pkg::pick_t               pick_o
);
  import rsa_pkg::*;

  // Scan from the top so the lowest set bit wins
  always_comb begin
    pick_o.found = |req_i;
    pick_o.idx   = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (req_i[i]) begin
        pick_o.idx = REG_W'(i);
      end
    end
  end

endmodule

FILE: rtl/register_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// register_slot_allocator_top: machine register slot allocator
// Keeps the owner id, width, initial width, pointer and saved flags of each
// machine register and serves allocate, release, widen and lookup commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start_i high
//   and busy_o low. busy_o is held low, so a command may be issued on every
//   cycle.
//   Result channel: exactly one result per command. done_o is high for one
//   cycle with the result fields; the receiver must take it then.
//   Path: the command goes into the input register, then table lookup,
//   priority encode and table update feed the result register and the table
//   together. Throughput: one command per cycle; each command sees the table
//   as left by the one before it.
//   Configuration: cfg_we_i writes cfg_wdata_i into the mask of cfg_idx_i at the
//   clock edge; users write only while no command is in flight (unchecked).
//   Reset: all registers free, saved flags clear, masks at their defaults,
//   no result pending.
// ----------------------------------------------------------------------------
module register_slot_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          cfg_we_i,
  input  logic [rsa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rsa_pkg::CFG_W-1:0]     cfg_wdata_i,
  // command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rsa_pkg::CMD_W-1:0]     command_i,
  input  logic [rsa_pkg::VID_W-1:0]     var_id_i,
  input  logic [rsa_pkg::OPW_W-1:0]     width_i,
  input  logic                          is_pointer_i,
  input  logic [rsa_pkg::RIDX_W-1:0]    reg_index_i,
  // result channel
  output logic                          done_o,
  output logic [rsa_pkg::STAT_W-1:0]    status_o,
  output logic [rsa_pkg::RIDX_W-1:0]    reg_out_o,
  output logic                          save_needed_o,
  output logic [rsa_pkg::OPW_W-1:0]     width_out_o,
  output logic [rsa_pkg::OPW_W-1:0]     init_width_out_o,
  output logic                          pointer_out_o
);
  import rsa_pkg::*;

  // Configuration masks
  logic [NUM_REGS-1:0] alloc_mask_q, save_mask_q;

  // Register table
  logic [ID_BITS-1:0] owner_q [NUM_REGS];
  logic [OPW_W-1:0]   ent_w_q [NUM_REGS];
  logic [OPW_W-1:0]   ent_iw_q [NUM_REGS];
  logic [NUM_REGS-1:0] ent_ptr_q, saved_q;

  // Input register
  logic               in_vld_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [ID_BITS-1:0] id_q;
  logic [OPW_W-1:0]   w_q;
  logic               ptr_q;
  logic [RIDX_W-1:0]  ri_q;

  // Result register
  logic               done_q;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [RIDX_W-1:0]  reg_out_q, reg_out_d;
  logic               save_q, save_d;
  logic [OPW_W-1:0]   wout_q, wout_d;
  logic [OPW_W-1:0]   iwout_q, iwout_d;
  logic               pout_q, pout_d;

  // Decode signals
  logic [NUM_REGS-1:0] free_vec, match_vec;
  pick_t               pick_clean, pick_save, pick_match;
  logic [REG_W-1:0]    ri_idx, sel;
  logic                ri_ok;
  logic                take, rel, wid;
  logic [OPW_W-1:0]    new_iw;

  assign busy_o = 1'b0;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_mask_q <= fit_mask(ALLOC_MASK_RST);
      save_mask_q  <= fit_mask(SAVE_MASK_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALLOC_MASK: alloc_mask_q <= fit_mask(cfg_wdata_i);
        CFG_SAVE_MASK:  save_mask_q  <= fit_mask(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Input register: the id is cast to the table's id width here (both 16 bits)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      cmd_q <= command_i;
      id_q  <= ID_BITS'(var_id_i);
      w_q   <= width_i;
      ptr_q <= is_pointer_i;
      ri_q  <= reg_index_i;
    end
  end

  // Free and id-match vectors
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      free_vec[i]  = (owner_q[i] == '0);
      match_vec[i] = (owner_q[i] != '0) && (owner_q[i] == id_q);
    end
  end

  rsa_lowest_set u_pick_clean (
    .req_i  (free_vec & alloc_mask_q & ~save_mask_q),
    .pick_o (pick_clean)
  );

  rsa_lowest_set u_pick_save (
    .req_i  (free_vec & alloc_mask_q & save_mask_q),
    .pick_o (pick_save)
  );

  rsa_lowest_set u_pick_match (
    .req_i  (match_vec),
    .pick_o (pick_match)
  );

  assign ri_idx = REG_W'(ri_q);
  assign ri_ok  = (int'(ri_q) < NUM_REGS);
  // 32/64-bit non-pointers start out at 64 bits
  assign new_iw = ((w_q >= OPW_32) && !ptr_q) ? OPW_64 : w_q;

  // Command decode and result fields
  always_comb begin
    status_d  = ST_OK;
    sel       = '0;
    take      = 1'b0;
    rel       = 1'b0;
    wid       = 1'b0;
    reg_out_d = '0;
    save_d    = 1'b0;
    wout_d    = '0;
    iwout_d   = '0;
    pout_d    = 1'b0;
    if (id_q == '0) begin
      status_d = ST_ZERO_ID;
    end else begin
      case (cmd_q)
        CMD_ALLOC_ANY: begin
          if (pick_clean.found) begin
            sel  = pick_clean.idx;
            take = 1'b1;
          end else if (pick_save.found) begin
            sel  = pick_save.idx;
            take = 1'b1;
          end else begin
            status_d = ST_NONE_FREE;
          end
        end
        CMD_ALLOC_FIXED: begin
          if (ri_ok && free_vec[ri_idx]) begin
            sel  = ri_idx;
            take = 1'b1;
          end else begin
            status_d = ST_REG_BUSY;
          end
        end
        CMD_RELEASE: begin
          sel = pick_match.idx;
          if (pick_match.found) begin
            rel = 1'b1;
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        CMD_WIDEN: begin
          sel = pick_match.idx;
          if (pick_match.found) begin
            wid = (w_q > ent_w_q[sel]) && !ent_ptr_q[sel];
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        default: begin
          // lookup, and the unused codes behave the same
          sel = pick_match.idx;
          if (!pick_match.found) begin
            status_d = ST_NOT_FOUND;
          end
        end
      endcase
    end

    if (status_d == ST_OK) begin
      reg_out_d = RIDX_W'(sel);
      if (take) begin
        save_d  = save_mask_q[sel] && !saved_q[sel];
        wout_d  = w_q;
        iwout_d = new_iw;
        pout_d  = ptr_q;
      end else begin
        wout_d  = ent_w_q[sel];
        iwout_d = wid ? w_q : ent_iw_q[sel];
        pout_d  = ent_ptr_q[sel];
      end
    end
  end

  // Table update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        owner_q[i]  <= '0;
        ent_w_q[i]  <= '0;
        ent_iw_q[i] <= '0;
      end
      ent_ptr_q <= '0;
      saved_q   <= '0;
    end else if (in_vld_q) begin
      if (take) begin
        owner_q[sel]   <= id_q;
        ent_w_q[sel]   <= w_q;
        ent_iw_q[sel]  <= new_iw;
        ent_ptr_q[sel] <= ptr_q;
        if (save_d) begin
          saved_q[sel] <= 1'b1;
        end
      end
      if (rel) begin
        owner_q[sel] <= '0;
      end
      if (wid) begin
        ent_iw_q[sel] <= w_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      status_q  <= status_d;
      reg_out_q <= reg_out_d;
      save_q    <= save_d;
      wout_q    <= wout_d;
      iwout_q   <= iwout_d;
      pout_q    <= pout_d;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign reg_out_o        = reg_out_q;
  assign save_needed_o    = save_q;
  assign width_out_o      = wout_q;
  assign init_width_out_o = iwout_q;
  assign pointer_out_o    = pout_q;

  // Checks
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |=> done_o)
    else $error("command in flight produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> !done_o)
    else $error("result without a command");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (reg_out_o == '0 && !save_needed_o &&
      width_out_o == '0 && init_width_out_o == '0 && !pointer_out_o))
    else $error("failed command carries non-zero fields");

  a_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && id_q == '0) |=> (done_o && status_o == ST_ZERO_ID))
    else $error("zero id not rejected");

  a_save_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && save_needed_o) |-> (status_o == ST_OK))
    else $error("save flagged on a failed command");

endmodule
